@@ rtl/shortest_path_trajectory_compressor_top_macros.svh @@
// Assertion macros for the shortest-path trajectory compressor.
// Used by the top level; expects clk and arst_n in scope.
`ifndef SHORTEST_PATH_TRAJECTORY_COMPRESSOR_TOP_MACROS_SVH
`define SHORTEST_PATH_TRAJECTORY_COMPRESSOR_TOP_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define SPTC_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Consequence that must hold in the same cycle as the antecedent.
`define SPTC_ASSERT_IMPLY(lbl, ant, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |-> (cons)) \
		else $error(msg);

// Consequence that must hold in the cycle after the antecedent.
`define SPTC_ASSERT_NEXT(lbl, ant, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/sptc_pkg.sv @@
// Package of the shortest-path trajectory compressor: defaults, codes and the result type.
// No dependencies; used by sptc_ram and shortest_path_trajectory_compressor_top.
package sptc_pkg;

	localparam int NODES_DEF     = 256;
	localparam int EDGE_BITS_DEF = 12;
	localparam int NODE_W        = 8;
	localparam int VALUE_W       = 12;
	localparam int KIND_W        = 2;

	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_EDGE = 1'b1;

	localparam logic [KIND_W-1:0] KIND_ANCHOR  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_LITERAL = 2'd1;
	localparam logic [KIND_W-1:0] KIND_END     = 2'd2;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [VALUE_W-1:0] value;
		logic               last;
	} res_t;

endpackage

@@ rtl/sptc_ram.sv @@
// Generic single-clock RAM with one write port and one registered read port.
// Depends on sptc_pkg for its default sizes.
module sptc_ram #(
	parameter int WIDTH = sptc_pkg::EDGE_BITS_DEF + 1,
	parameter int DEPTH = sptc_pkg::NODES_DEF * sptc_pkg::NODES_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/shortest_path_trajectory_compressor_top.sv @@
// Top level of the shortest-path trajectory compressor: item register, table sequencer,
// result queue. Depends on sptc_pkg, sptc_ram and the assertion macro header.
//
// Channel  Dir  tdata (low bit up)                                   tuser  tlast
// s_*      in   src_node, dst_node, has_path, edge_id, tail, head    func   last_edge
// m_*      out  value                                                kind   last
//
// A table load is written at issue. An edge is read and checked; when an open run breaks
// it is read again from the run's head and checked anew, as the table memory has one
// registered read port. After reset the table is cleared, one entry a cycle, through all
// 2**(2*max(1,ceil(log2(min(NODES,256))))) entries (65536 by default), and no word is
// taken meanwhile. Results wait in a four-word queue, so a stalled output only holds
// the input once the queue cannot take two more words.
`include "shortest_path_trajectory_compressor_top_macros.svh"

module shortest_path_trajectory_compressor_top #(
	parameter int NODES     = sptc_pkg::NODES_DEF,
	parameter int EDGE_BITS = sptc_pkg::EDGE_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // src_node, dst_node, has_path, edge_id, edge_tail, edge_head
	input  logic        s_tuser,  // func
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // value
	output logic [1:0]  m_tuser,  // kind
	output logic        m_tlast
);

	localparam int NUSE  = (NODES < 256) ? NODES : 256;
	localparam int ND    = (NUSE > 1) ? $clog2(NUSE) : 1;
	localparam int AW    = 2 * ND;
	localparam int DEPTH = 1 << AW;
	localparam int TW    = EDGE_BITS + 1;
	localparam int NW    = sptc_pkg::NODE_W;
	localparam int VW    = sptc_pkg::VALUE_W;

	localparam logic [1:0] PH_ISSUE = 2'd0;
	localparam logic [1:0] PH_CHK1  = 2'd1;
	localparam logic [1:0] PH_CHK2  = 2'd2;

	function automatic logic node_ok(input logic [NW-1:0] n);
		return int'(n) < NODES;
	endfunction

	logic                 clr_q;
	logic [AW-1:0]        clr_addr_q;
	logic                 itm_vld_q;
	logic [1:0]           ph_q, ph_d;
	logic                 func_q, has_q, last_q;
	logic [NW-1:0]        src_q, dst_q, tail_q, head_q;
	logic [EDGE_BITS-1:0] edge_q;
	logic [NW-1:0]        anchor_q, anchor_d, rhead_q, rhead_d;
	logic                 in_run_q, in_run_d, prev_q, prev_d, at_start_q, at_start_d;
	logic                 rng_q, rng_d;

	logic                 ram_we, ram_re;
	logic [AW-1:0]        ram_waddr, ram_raddr;
	logic [TW-1:0]        ram_wdata, ram_rdata;

	logic [NW-1:0]        a_iss;
	logic                 hit, fin, res_step, room, accept, pop;
	logic                 main_v;
	sptc_pkg::res_t       main_r, r0, r1;
	logic [1:0]           push_n;

	sptc_pkg::res_t       fifo_q [4];
	logic [1:0]           wptr_q, rptr_q;
	logic [2:0]           cnt_q;

	sptc_ram #(
		.WIDTH(TW),
		.DEPTH(DEPTH)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign a_iss  = at_start_q ? tail_q : anchor_q;
	assign hit    = rng_q && ram_rdata[EDGE_BITS] && (ram_rdata[EDGE_BITS-1:0] == edge_q);
	assign room   = (cnt_q <= 3'd2);
	assign accept = s_tvalid && s_tready;
	assign pop    = m_tvalid && m_tready;

	assign s_tready = !clr_q && (!itm_vld_q || fin);

	always_comb begin
		anchor_d   = anchor_q;
		rhead_d    = rhead_q;
		in_run_d   = in_run_q;
		prev_d     = prev_q;
		at_start_d = at_start_q;
		rng_d      = rng_q;
		ph_d       = ph_q;
		ram_we     = 1'b0;
		ram_waddr  = clr_addr_q;
		ram_wdata  = '0;
		ram_re     = 1'b0;
		ram_raddr  = {a_iss[ND-1:0], head_q[ND-1:0]};
		fin        = 1'b0;
		res_step   = 1'b0;
		main_v     = 1'b0;
		main_r     = '0;
		r0         = '0;
		r1         = '0;
		push_n     = 2'd0;

		if (clr_q) begin
			ram_we = 1'b1;
		end else if (itm_vld_q) begin
			case (ph_q)
				PH_ISSUE: begin
					if (func_q == sptc_pkg::FUNC_LOAD) begin
						ram_we    = node_ok(src_q) && node_ok(dst_q);
						ram_waddr = {src_q[ND-1:0], dst_q[ND-1:0]};
						ram_wdata = has_q ? {1'b1, edge_q} : '0;
						fin       = 1'b1;
					end else begin
						if (at_start_q) begin
							anchor_d   = tail_q;
							in_run_d   = 1'b0;
							prev_d     = 1'b0;
							at_start_d = 1'b0;
						end
						ram_re = 1'b1;
						rng_d  = node_ok(a_iss) && node_ok(head_q);
						ph_d   = PH_CHK1;
					end
				end
				PH_CHK1: begin
					if (in_run_q && !hit) begin
						anchor_d  = rhead_q;
						in_run_d  = 1'b0;
						ram_re    = 1'b1;
						ram_raddr = {rhead_q[ND-1:0], head_q[ND-1:0]};
						rng_d     = node_ok(rhead_q) && node_ok(head_q);
						ph_d      = PH_CHK2;
					end else if (room) begin
						res_step = 1'b1;
					end
				end
				PH_CHK2: begin
					if (room) begin
						res_step = 1'b1;
					end
				end
				default: begin
					ph_d = PH_ISSUE;
				end
			endcase
		end

		if (res_step) begin
			fin  = 1'b1;
			ph_d = PH_ISSUE;
			if (in_run_q && hit) begin
				rhead_d = head_q;
			end else if (hit) begin
				main_v       = !prev_q;
				main_r.kind  = sptc_pkg::KIND_ANCHOR;
				main_r.value = VW'(anchor_q);
				prev_d       = 1'b0;
				in_run_d     = 1'b1;
				rhead_d      = head_q;
			end else begin
				main_v       = 1'b1;
				main_r.kind  = sptc_pkg::KIND_LITERAL;
				main_r.value = VW'(edge_q);
				prev_d       = 1'b1;
				anchor_d     = head_q;
			end
			if (last_q) begin
				at_start_d = 1'b1;
				in_run_d   = 1'b0;
				prev_d     = 1'b0;
			end
			if (main_v) begin
				r0      = main_r;
				r0.last = !last_q;
				r1      = '{kind: sptc_pkg::KIND_END, value: VW'(head_q), last: 1'b1};
				push_n  = last_q ? 2'd2 : 2'd1;
			end else if (last_q) begin
				r0     = '{kind: sptc_pkg::KIND_END, value: VW'(head_q), last: 1'b1};
				push_n = 2'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
			itm_vld_q  <= 1'b0;
			ph_q       <= PH_ISSUE;
			anchor_q   <= '0;
			rhead_q    <= '0;
			in_run_q   <= 1'b0;
			prev_q     <= 1'b0;
			at_start_q <= 1'b1;
			rng_q      <= 1'b0;
			wptr_q     <= '0;
			rptr_q     <= '0;
			cnt_q      <= '0;
		end else begin
			if (clr_q) begin
				clr_addr_q <= clr_addr_q + AW'(1);
				if (&clr_addr_q) begin
					clr_q <= 1'b0;
				end
			end
			itm_vld_q  <= accept || (itm_vld_q && !fin);
			ph_q       <= ph_d;
			anchor_q   <= anchor_d;
			rhead_q    <= rhead_d;
			in_run_q   <= in_run_d;
			prev_q     <= prev_d;
			at_start_q <= at_start_d;
			rng_q      <= rng_d;
			wptr_q     <= wptr_q + push_n;
			rptr_q     <= rptr_q + 2'(pop);
			cnt_q      <= cnt_q + 3'(push_n) - 3'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= s_tuser;
			src_q  <= s_tdata[7:0];
			dst_q  <= s_tdata[15:8];
			has_q  <= s_tdata[16];
			edge_q <= EDGE_BITS'(s_tdata[28:17]);
			tail_q <= s_tdata[36:29];
			head_q <= s_tdata[44:37];
			last_q <= s_tlast;
		end
		if (push_n != 2'd0) begin
			fifo_q[wptr_q] <= r0;
		end
		if (push_n == 2'd2) begin
			fifo_q[wptr_q + 2'd1] <= r1;
		end
	end

	assign m_tvalid = (cnt_q != 3'd0);
	assign m_tdata  = 16'(fifo_q[rptr_q].value);
	assign m_tuser  = fifo_q[rptr_q].kind;
	assign m_tlast  = fifo_q[rptr_q].last;

	`SPTC_ASSERT_ALWAYS(a_queue_bound, cnt_q <= 3'd4, "Result queue count beyond its depth.")
	`SPTC_ASSERT_IMPLY(a_clear_quiet, clr_q, !s_tready && !m_tvalid, "Activity during the table clear.")
	`SPTC_ASSERT_NEXT(a_second_read, itm_vld_q && ph_q == PH_CHK1 && ram_re, ph_q == PH_CHK2 && !in_run_q, "Second lookup without a closed run.")
	`SPTC_ASSERT_IMPLY(a_end_last, m_tvalid && m_tuser == sptc_pkg::KIND_END, m_tlast, "End node word not marked last.")

endmodule
